// ----- hdl/dtbp_pkg.sv -----
package dtbp_pkg;

  // Field widths fixed by the request and result formats.
  localparam int LEVEL_W   = 48;
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 32;
  localparam int SHARE_W   = 17;
  localparam int PTYPE_W   = 8;
  localparam int SIZE_W    = 16;
  localparam int DEPTH_W   = 24;
  localparam int STAGE_W   = 2;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_AGG_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SHARE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTYPE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 3'd4;

  // Register reset values.
  localparam logic [SHARE_W-1:0] SHARE_ONE = 17'h10000;
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 24'd65536;

  // Drop stage codes.
  localparam logic [STAGE_W-1:0] STAGE_NONE = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_TYPE = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_AGG  = 2'd2;

  // Request payload as captured by the datapath.
  typedef struct packed {
    logic               action;
    logic [TIME_W-1:0]  now;
    logic [PTYPE_W-1:0] packet_type;
    logic [SIZE_W-1:0]  packet_size;
    logic               mine;
    logic               low_demand;
  } dtbp_req_t;

  // Result payload.
  typedef struct packed {
    logic               dropped;
    logic [STAGE_W-1:0] drop_stage;
    logic [LEVEL_W-1:0] aggregate_level;
    logic [LEVEL_W-1:0] type_level;
  } dtbp_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_trate;
    logic mul_bucket;
    logic fill;
    logic charge;
    logic sel_type;
    logic clear;
    logic out_load;
  } dtbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic type_hit;
    logic drop;
  } dtbp_sts_t;

endpackage

// ----- hdl/dtbp_in_if.sv -----
interface dtbp_in_if;
  import dtbp_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [TIME_W-1:0]  now;
  logic [PTYPE_W-1:0] packet_type;
  logic [SIZE_W-1:0]  packet_size;
  logic               mine;
  logic               low_demand;

  modport source (
    output valid, action, now, packet_type, packet_size, mine, low_demand,
    input  ready
  );

  modport sink (
    input  valid, action, now, packet_type, packet_size, mine, low_demand,
    output ready
  );

endinterface

// ----- hdl/dtbp_out_if.sv -----
interface dtbp_out_if;
  import dtbp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      dropped;
  logic [STAGE_W-1:0]        drop_stage;
  logic signed [LEVEL_W-1:0] aggregate_level;
  logic signed [LEVEL_W-1:0] type_level;

  modport source (
    output valid, dropped, drop_stage, aggregate_level, type_level,
    input  ready
  );

  modport sink (
    input  valid, dropped, drop_stage, aggregate_level, type_level,
    output ready
  );

endinterface

// ----- hdl/dtbp_datapath.sv -----
module dtbp_datapath #(
  parameter int TOKEN_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtbp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [dtbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  dtbp_pkg::dtbp_req_t                 req,
  input  dtbp_pkg::dtbp_cmd_t                 cmd,
  output dtbp_pkg::dtbp_sts_t                 sts,
  output dtbp_pkg::dtbp_res_t                 res
);
  import dtbp_pkg::*;

  localparam int EXT_W = LEVEL_W + 1;
  localparam int REFILL_W = 2 * RATE_W - 3;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
  localparam logic [LEVEL_W-1:0] TOKENS_RST =
    LEVEL_W'(DEPTH_RST) << TOKEN_FRAC_BITS;

  // Configuration registers.
  logic [RATE_W-1:0]  rate_r;
  logic [SHARE_W-1:0] share_r;
  logic [PTYPE_W-1:0] rtype_r;
  logic               type_en_r;
  logic [DEPTH_W-1:0] depth_r;

  // Bucket state.
  logic [LEVEL_W-1:0] agg_tok_r, typ_tok_r;
  logic [TIME_W-1:0]  agg_last_r, typ_last_r;

  // Captured request and working registers.
  logic [TIME_W-1:0]   now_r;
  logic [SIZE_W-1:0]   size_r;
  logic                forced_r;
  logic [2*RATE_W-1:0] prod_r;
  logic [LEVEL_W-1:0]  fill_r;
  logic [STAGE_W-1:0]  stage_r;
  dtbp_res_t           res_r;

  logic [SHARE_W-1:0]  share_sat;
  logic [TIME_W-1:0]   last_sel, elapsed;
  logic [LEVEL_W-1:0]  tok_sel;
  logic [RATE_W-1:0]   mul_a, mul_b;
  logic [2*RATE_W-1:0] prod_nxt;
  logic [REFILL_W-1:0] refill;
  logic [EXT_W-1:0]    cap_ext, tok_ext, room;
  logic                at_cap, refill_big;
  logic [LEVEL_W-1:0]  fill_nxt;
  logic [EXT_W-1:0]    cost_ext, fill_ext, diff;
  logic                pass;
  logic [LEVEL_W-1:0]  charged, tok_nxt;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= '0;
      share_r   <= SHARE_ONE;
      rtype_r   <= '0;
      type_en_r <= 1'b0;
      depth_r   <= DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_AGG_RATE:   rate_r    <= cfg_data[RATE_W-1:0];
        CFG_TYPE_SHARE: share_r   <= cfg_data[SHARE_W-1:0];
        CFG_RTYPE:      rtype_r   <= cfg_data[PTYPE_W-1:0];
        CFG_TYPE_EN:    type_en_r <= cfg_data[0];
        CFG_DEPTH:      depth_r   <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Bucket select and the shared multiplier.
  assign share_sat = (share_r > SHARE_ONE) ? SHARE_ONE : share_r;
  assign last_sel  = cmd.sel_type ? typ_last_r : agg_last_r;
  assign tok_sel   = cmd.sel_type ? typ_tok_r : agg_tok_r;
  assign elapsed   = now_r - last_sel;
  assign mul_a     = cmd.mul_trate ? rate_r : elapsed;
  // In the type pass the product register still holds rate times share.
  assign mul_b     = cmd.mul_trate ? RATE_W'(share_sat) :
                     (cmd.sel_type ? prod_r[RATE_W+15:16] : rate_r);
  assign prod_nxt  = mul_a * mul_b;

  // Refill and cap at the bucket depth.
  assign refill     = prod_r[2*RATE_W-1:3];
  assign cap_ext    = EXT_W'(depth_r) << TOKEN_FRAC_BITS;
  assign tok_ext    = {tok_sel[LEVEL_W-1], tok_sel};
  assign at_cap     = $signed(tok_ext) >= $signed(cap_ext);
  assign room       = cap_ext - tok_ext;
  assign refill_big = refill >= REFILL_W'(room);
  assign fill_nxt   = (at_cap || refill_big) ? cap_ext[LEVEL_W-1:0]
                                             : tok_sel + refill[LEVEL_W-1:0];

  // Test against the packet cost and charge, saturating deep debt.
  assign cost_ext = EXT_W'(size_r) << TOKEN_FRAC_BITS;
  assign fill_ext = {fill_r[LEVEL_W-1], fill_r};
  assign pass     = ($signed(cost_ext) < $signed(fill_ext)) || forced_r;
  assign diff     = fill_ext - cost_ext;
  assign charged  = (diff[EXT_W-1] && !diff[LEVEL_W-1]) ? LEVEL_MIN : diff[LEVEL_W-1:0];
  assign tok_nxt  = pass ? charged : fill_r;

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r    <= req.now;
      size_r   <= req.packet_size;
      forced_r <= req.mine && req.low_demand;
    end
    if (cmd.mul_trate || cmd.mul_bucket) begin
      prod_r <= prod_nxt;
    end
    if (cmd.fill) begin
      fill_r <= fill_nxt;
    end
  end

  // Drop stage of the current packet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= STAGE_NONE;
    end else if (cmd.load) begin
      stage_r <= STAGE_NONE;
    end else if (cmd.charge && !pass) begin
      stage_r <= cmd.sel_type ? STAGE_TYPE : STAGE_AGG;
    end
  end

  // Bucket state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_tok_r  <= TOKENS_RST;
      typ_tok_r  <= TOKENS_RST;
      agg_last_r <= '0;
      typ_last_r <= '0;
    end else if (cmd.clear) begin
      agg_tok_r  <= '0;
      typ_tok_r  <= '0;
      agg_last_r <= now_r;
      typ_last_r <= now_r;
    end else if (cmd.charge) begin
      if (cmd.sel_type) begin
        typ_tok_r  <= tok_nxt;
        typ_last_r <= now_r;
      end else begin
        agg_tok_r  <= tok_nxt;
        agg_last_r <= now_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r.dropped         <= (stage_r != STAGE_NONE);
      res_r.drop_stage      <= stage_r;
      res_r.aggregate_level <= agg_tok_r;
      res_r.type_level      <= typ_tok_r;
    end
  end

  assign res          = res_r;
  assign sts.action   = req.action;
  assign sts.type_hit = type_en_r && (req.packet_type == rtype_r);
  assign sts.drop     = !pass;

endmodule

// ----- hdl/dtbp_ctrl.sv -----
module dtbp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dtbp_pkg::dtbp_sts_t sts,
  output dtbp_pkg::dtbp_cmd_t cmd
);
  import dtbp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_TRATE = 4'd2;
  localparam logic [3:0] S_TMUL  = 4'd3;
  localparam logic [3:0] S_TFILL = 4'd4;
  localparam logic [3:0] S_TCHG  = 4'd5;
  localparam logic [3:0] S_AMUL  = 4'd6;
  localparam logic [3:0] S_AFILL = 4'd7;
  localparam logic [3:0] S_ACHG  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state and per-state commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.action) begin
            state_nxt = S_CLEAR;
          end else if (sts.type_hit) begin
            state_nxt = S_TRATE;
          end else begin
            state_nxt = S_AMUL;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_DONE;
      end
      S_TRATE: begin
        cmd.mul_trate = 1'b1;
        cmd.sel_type  = 1'b1;
        state_nxt     = S_TMUL;
      end
      S_TMUL: begin
        cmd.mul_bucket = 1'b1;
        cmd.sel_type   = 1'b1;
        state_nxt      = S_TFILL;
      end
      S_TFILL: begin
        cmd.fill     = 1'b1;
        cmd.sel_type = 1'b1;
        state_nxt    = S_TCHG;
      end
      S_TCHG: begin
        cmd.charge   = 1'b1;
        cmd.sel_type = 1'b1;
        state_nxt    = sts.drop ? S_DONE : S_AMUL;
      end
      S_AMUL: begin
        cmd.mul_bucket = 1'b1;
        state_nxt      = S_AFILL;
      end
      S_AFILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_ACHG;
      end
      S_ACHG: begin
        cmd.charge = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted request did not start work");

  // A finished request with a free output register produces a result.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished request did not produce a result");

  // A type bucket drop skips the aggregate bucket.
  a_type_drop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TCHG && sts.drop |=> state_r == S_DONE)
    else $error("aggregate bucket visited after a type drop");

  // A bucket reset goes from the clear state straight to the done state.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |=> state_r == S_DONE)
    else $error("bucket reset did not finish");
`endif

endmodule

// ----- hdl/dual_token_bucket_policer.sv -----
// Dual token bucket policer.
// Requests arrive on in_ch (valid/ready): action 0 polices one packet, action 1
// empties both buckets and stamps them with the request time. Each request
// gives exactly one result on out_ch (valid/ready): the drop flag, the stage
// that dropped the packet, and both bucket levels after the request.
// Buckets are policed one request at a time through one shared 32x32
// multiplier and one refill/charge path. out_ch.valid rises as the controller
// leaves its done state: a bucket reset passes the clear state, a packet the
// type rate, multiply, fill and charge states if its type is restricted, then,
// unless dropped there, the aggregate multiply, fill and charge states.
// in_ch.ready rises in that same cycle; requests are taken one at a time.
// The result register holds the last result, so one request can be worked on
// while a result waits.
// If out_ch stalls, a finished request waits until the result register is
// free and no further request is taken meanwhile.
// Synchronous reset (rst_n low) fills both buckets to 65536 bytes, zeroes
// their timestamps and restores the register defaults. cfg_we writes
// register cfg_idx at the next clock edge; write only while idle.
module dual_token_bucket_policer #(
  parameter int TOKEN_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dtbp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dtbp_pkg::CFG_DATA_W-1:0] cfg_data,
  dtbp_in_if.sink                         in_ch,
  dtbp_out_if.source                      out_ch
);
  import dtbp_pkg::*;

  dtbp_req_t req;
  dtbp_res_t res;
  dtbp_cmd_t cmd;
  dtbp_sts_t sts;

  assign req.action      = in_ch.action;
  assign req.now         = in_ch.now;
  assign req.packet_type = in_ch.packet_type;
  assign req.packet_size = in_ch.packet_size;
  assign req.mine        = in_ch.mine;
  assign req.low_demand  = in_ch.low_demand;

  dtbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtbp_datapath #(
    .TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .res      (res)
  );

  assign out_ch.dropped         = res.dropped;
  assign out_ch.drop_stage      = res.drop_stage;
  assign out_ch.aggregate_level = $signed(res.aggregate_level);
  assign out_ch.type_level      = $signed(res.type_level);

endmodule

// ----- dv/tb_dual_token_bucket_policer.sv -----
module tb_dual_token_bucket_policer;
  import dtbp_pkg::*;

  localparam int     FRAC          = 8;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     PHASES        = 9;
  localparam int     PHASE_ITEMS   = 150;
  localparam longint LEVEL_FLOOR   = -(longint'(1) <<< 47);

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dtbp_in_if  in_ch ();
  dtbp_out_if out_ch ();

  dual_token_bucket_policer #(
    .TOKEN_FRAC_BITS (FRAC)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Register mirror and bucket state of the policer as the testbench sees it.
  logic [RATE_W-1:0]  agg_rate_q;
  logic [SHARE_W-1:0] share_q;
  logic [PTYPE_W-1:0] rtype_q;
  logic               type_en_q;
  logic [DEPTH_W-1:0] depth_q;
  longint             agg_tokens;
  longint             type_tokens;
  logic [TIME_W-1:0]  agg_stamp;
  logic [TIME_W-1:0]  type_stamp;

  dtbp_res_t          expected_results[$];
  int                 mismatches;
  bit                 pace_on;
  logic [TIME_W-1:0]  traffic_time;
  int                 n_resets;
  int                 n_passed;
  int                 n_type_drops;
  int                 n_agg_drops;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Refill one bucket for the elapsed ticks, cap it, then test and charge the packet.
  // Returns 1 when the bucket drops the packet.
  function automatic bit charge_bucket(inout longint tokens, inout logic [TIME_W-1:0] stamp,
                                       input logic [TIME_W-1:0] now,
                                       input logic [RATE_W-1:0] rate,
                                       input logic [SIZE_W-1:0] size, input bit forced);
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       refill;
    longint            cap;
    longint            cost;
    longint            lvl;
    elapsed = now - stamp;
    refill  = (64'(elapsed) * 64'(rate)) >> 3;
    cap     = longint'(64'(depth_q) << FRAC);
    cost    = longint'(64'(size) << FRAC);
    lvl     = tokens;
    stamp   = now;
    if (lvl >= cap || refill >= unsigned'(cap - lvl)) begin
      lvl = cap;
    end else begin
      lvl = lvl + longint'(refill);
    end
    if (cost < lvl || forced) begin
      lvl = lvl - cost;
      if (lvl < LEVEL_FLOOR) begin
        lvl = LEVEL_FLOOR;
      end
      tokens = lvl;
      return 1'b0;
    end
    tokens = lvl;
    return 1'b1;
  endfunction

  // Work out the verdict and both levels for one request, updating the bucket state.
  function automatic dtbp_res_t predict_policing(input dtbp_req_t r);
    dtbp_res_t          res;
    logic [SHARE_W-1:0] share;
    logic [RATE_W-1:0]  type_rate;
    bit                 forced;
    bit                 drop_here;
    res    = '0;
    forced = r.mine && r.low_demand;
    if (r.action) begin
      agg_tokens  = 0;
      type_tokens = 0;
      agg_stamp   = r.now;
      type_stamp  = r.now;
    end else begin
      // The type bucket only sees the restricted type, and only when enabled.
      if (type_en_q && r.packet_type == rtype_q) begin
        share     = (share_q > SHARE_ONE) ? SHARE_ONE : share_q;
        type_rate = RATE_W'((64'(agg_rate_q) * 64'(share)) >> 16);
        drop_here = charge_bucket(type_tokens, type_stamp, r.now, type_rate,
                                  r.packet_size, forced);
        if (drop_here) begin
          res.dropped    = 1'b1;
          res.drop_stage = STAGE_TYPE;
        end
      end
      if (!res.dropped) begin
        drop_here = charge_bucket(agg_tokens, agg_stamp, r.now, agg_rate_q,
                                  r.packet_size, forced);
        if (drop_here) begin
          res.dropped    = 1'b1;
          res.drop_stage = STAGE_AGG;
        end
      end
    end
    res.aggregate_level = agg_tokens[LEVEL_W-1:0];
    res.type_level      = type_tokens[LEVEL_W-1:0];
    return res;
  endfunction

  function automatic dtbp_req_t make_req(input logic action, input logic [TIME_W-1:0] now,
                                         input logic [PTYPE_W-1:0] ptype,
                                         input logic [SIZE_W-1:0] size,
                                         input logic mine, input logic low_demand);
    dtbp_req_t r;
    r.action      = action;
    r.now         = now;
    r.packet_type = ptype;
    r.packet_size = size;
    r.mine        = mine;
    r.low_demand  = low_demand;
    return r;
  endfunction

  // Offer one request, wait for the handshake and queue the expected result.
  task automatic send_request(input dtbp_req_t r);
    int        gap;
    dtbp_res_t res;
    gap = pace_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.action      = r.action;
    in_ch.now         = r.now;
    in_ch.packet_type = r.packet_type;
    in_ch.packet_size = r.packet_size;
    in_ch.mine        = r.mine;
    in_ch.low_demand  = r.low_demand;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = predict_policing(r);
    expected_results.push_back(res);
    if (r.action) begin
      n_resets++;
    end else if (res.drop_stage == STAGE_TYPE) begin
      n_type_drops++;
    end else if (res.drop_stage == STAGE_AGG) begin
      n_agg_drops++;
    end else begin
      n_passed++;
    end
    @(negedge clk);
  endtask

  // Hold off new requests until every outstanding result has been returned.
  task automatic wait_until_idle();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_AGG_RATE:   agg_rate_q = data[RATE_W-1:0];
      CFG_TYPE_SHARE: share_q    = data[SHARE_W-1:0];
      CFG_RTYPE:      rtype_q    = data[PTYPE_W-1:0];
      CFG_TYPE_EN:    type_en_q  = data[0];
      CFG_DEPTH:      depth_q    = data[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram all registers once the policer has gone quiet.
  task automatic configure(input logic [RATE_W-1:0] rate, input logic [SHARE_W-1:0] share,
                           input logic [PTYPE_W-1:0] rtype, input logic en,
                           input logic [DEPTH_W-1:0] depth);
    wait_until_idle();
    write_reg(CFG_AGG_RATE, CFG_DATA_W'(rate));
    write_reg(CFG_TYPE_SHARE, CFG_DATA_W'(share));
    write_reg(CFG_RTYPE, CFG_DATA_W'(rtype));
    write_reg(CFG_TYPE_EN, CFG_DATA_W'(en));
    write_reg(CFG_DEPTH, CFG_DATA_W'(depth));
  endtask

  // Field extremes with the reset register values: full bucket, zero rate.
  task automatic test_field_extremes();
    send_request(make_req(1'b0, 32'h0, 8'h00, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0, 1'b0));
    // Only one byte of credit is left, so a one-byte packet is not strictly below it.
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'hFF, 16'h0001, 1'b0, 1'b0));
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b0, 1'b0));
    // Mine with low demand forces a pass and drives the bucket into debt.
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'h00, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b1, 1'b0));
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'h00, 16'h0000, 1'b0, 1'b1));
  endtask

  // The reset action empties both buckets and stamps them with the request time.
  task automatic test_bucket_reset();
    send_request(make_req(1'b1, 32'h0012_3456, 8'h5A, 16'h1234, 1'b0, 1'b1));
    send_request(make_req(1'b0, 32'h0012_3456, 8'h00, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
  endtask

  // Type bucket in front of the aggregate one, under extreme register settings.
  task automatic test_type_bucket();
    configure(32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 1'b1, 24'hFF_FFFF);
    // No time has passed since the reset action, so the empty type bucket drops.
    send_request(make_req(1'b0, 32'hFFFF_FFFF, 8'hFF, 16'h0000, 1'b0, 1'b0));
    // Time wraps past zero: one tick of refill at the clamped full share.
    send_request(make_req(1'b0, 32'h0000_0000, 8'hFF, 16'h0064, 1'b0, 1'b0));
    send_request(make_req(1'b0, 32'h8000_0000, 8'hFF, 16'hFFFF, 1'b0, 1'b0));
    // Time going backwards counts as a huge elapsed interval.
    send_request(make_req(1'b0, 32'h0000_0005, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
    // An unrestricted type skips the type bucket, whose level is still reported.
    send_request(make_req(1'b0, 32'h0000_0006, 8'h7F, 16'hFFFF, 1'b0, 1'b0));

    // Zero depth and a share that truncates the type rate to zero.
    configure(32'h0000_0001, SHARE_ONE - 17'd1, 8'h00, 1'b1, 24'h00_0000);
    send_request(make_req(1'b0, 32'h0000_0007, 8'h00, 16'h0000, 1'b0, 1'b0));
    send_request(make_req(1'b0, 32'h0000_0008, 8'h00, 16'hFFFF, 1'b1, 1'b1));
    send_request(make_req(1'b0, 32'h0000_0009, 8'h01, 16'h0000, 1'b0, 1'b0));

    // Type bucket disabled: the restricted type only meets the aggregate bucket.
    configure(32'h0000_0800, 17'h08000, 8'hAA, 1'b0, 24'd100);
    send_request(make_req(1'b0, 32'd1000, 8'hAA, 16'd50, 1'b0, 1'b0));
    send_request(make_req(1'b0, 32'd2000, 8'h55, 16'd99, 1'b0, 1'b0));
  endtask

  // Long runs of mostly well-formed traffic with a steadily advancing clock.
  task automatic test_random_traffic();
    dtbp_req_t          r;
    int                 roll;
    logic [RATE_W-1:0]  rate;
    logic [SHARE_W-1:0] share;
    logic [DEPTH_W-1:0] depth;
    traffic_time = $urandom;
    for (int phase = 0; phase < PHASES; phase++) begin
      pace_on = (phase % 3 != 1);
      if (phase == 0) begin
        configure(32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 1'b1, 24'hFF_FFFF);
      end else if (phase == 1) begin
        configure(32'h0, 17'h0, 8'h00, 1'b1, 24'h0);
      end else begin
        roll = $urandom_range(0, 9);
        if (roll == 0) rate = $urandom;
        else if (roll == 1) rate = $urandom_range(0, 255);
        else rate = $urandom_range(2000, 300000);
        if ($urandom_range(0, 6) == 0) share = SHARE_W'($urandom_range(65537, 17'h1FFFF));
        else share = SHARE_W'($urandom_range(0, 65536));
        roll = $urandom_range(0, 9);
        if (roll == 0) depth = DEPTH_W'($urandom);
        else if (roll == 1) depth = DEPTH_W'($urandom_range(0, 100));
        else depth = DEPTH_W'($urandom_range(500, 20000));
        configure(rate, share, PTYPE_W'($urandom_range(0, 3)), $urandom_range(0, 3) != 0,
                  depth);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Midway through each phase, let the pipeline drain completely.
        if (n == PHASE_ITEMS / 2) begin
          wait_until_idle();
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          traffic_time = $urandom;
        end else if (roll < 8) begin
          traffic_time = traffic_time + $urandom_range(0, 4000);
        end else begin
          traffic_time = traffic_time + $urandom_range(0, 40);
        end
        r.action      = ($urandom_range(0, 99) < 3);
        r.now         = traffic_time;
        r.packet_type = ($urandom_range(0, 4) == 0) ? PTYPE_W'($urandom)
                                                    : PTYPE_W'($urandom_range(0, 3));
        roll = $urandom_range(0, 19);
        if (roll < 2) r.packet_size = SIZE_W'($urandom);
        else if (roll == 2) r.packet_size = '0;
        else r.packet_size = SIZE_W'($urandom_range(1, 1500));
        r.mine        = 1'($urandom);
        r.low_demand  = ($urandom_range(0, 4) == 0);
        send_request(r);
      end
    end
  endtask

  // Result side: a random stall before each result while pacing is on.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = pace_on ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  function automatic void compare_field(input string name, input logic [LEVEL_W-1:0] want,
                                        input logic [LEVEL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    dtbp_res_t oldest;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding: dropped %b stage %0d agg %h type %h",
                 $time, out_ch.dropped, out_ch.drop_stage, out_ch.aggregate_level,
                 out_ch.type_level);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        compare_field("dropped", LEVEL_W'(oldest.dropped), LEVEL_W'(out_ch.dropped));
        compare_field("drop_stage", LEVEL_W'(oldest.drop_stage), LEVEL_W'(out_ch.drop_stage));
        compare_field("aggregate_level", oldest.aggregate_level, out_ch.aggregate_level);
        compare_field("type_level", oldest.type_level, out_ch.type_level);
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = 1'b0;
    in_ch.now         = '0;
    in_ch.packet_type = '0;
    in_ch.packet_size = '0;
    in_ch.mine        = 1'b0;
    in_ch.low_demand  = 1'b0;
    mismatches        = 0;
    pace_on           = 1'b1;
    n_resets          = 0;
    n_passed          = 0;
    n_type_drops      = 0;
    n_agg_drops       = 0;

    // Register defaults and full buckets after reset.
    agg_rate_q  = '0;
    share_q     = SHARE_ONE;
    rtype_q     = '0;
    type_en_q   = 1'b0;
    depth_q     = DEPTH_RST;
    agg_tokens  = longint'(64'(DEPTH_RST) << FRAC);
    type_tokens = agg_tokens;
    agg_stamp   = '0;
    type_stamp  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_bucket_reset();
    test_type_bucket();
    test_random_traffic();
    wait_until_idle();

    $display("Policed %0d packets (%0d passed, %0d type-bucket drops, %0d aggregate drops)",
             n_passed + n_type_drops + n_agg_drops, n_passed, n_type_drops, n_agg_drops);
    $display("and %0d bucket resets over %0d register settings.", n_resets, PHASES + 4);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
